FILE: hw/rtl/u8san_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u8san_pkg
// Shared types and constants of the UTF-8 sanitizer: the command that the
// front part hands to the back part, and the replacement character bytes.
// ----------------------------------------------------------------------------
package u8san_pkg;

  // Default depth of the command queue between front and back.
  localparam int QUEUE_DEPTH = 4;

  // Bytes of the replacement character U+FFFD.
  localparam logic [7:0] REPL_BYTE0 = 8'hEF;
  localparam logic [7:0] REPL_BYTE1 = 8'hBF;
  localparam logic [7:0] REPL_BYTE2 = 8'hBD;

  // Position inside one replacement character.
  localparam logic [1:0] REPL_PH0 = 2'd0;
  localparam logic [1:0] REPL_PH1 = 2'd1;
  localparam logic [1:0] REPL_PH2 = 2'd2;

  // Code point limits.
  localparam logic [20:0] CP_MAX      = 21'h10FFFF;
  localparam logic [20:0] CP_SURR_LO  = 21'h00D800;
  localparam logic [20:0] CP_SURR_HI  = 21'h00DFFF;
  localparam logic [20:0] CP_MIN_LEN2 = 21'h000080;
  localparam logic [20:0] CP_MIN_LEN3 = 21'h000800;
  localparam logic [20:0] CP_MIN_LEN4 = 21'h010000;

  // Sequence lengths.
  localparam logic [2:0] SEQ_LEN2 = 3'd2;
  localparam logic [2:0] SEQ_LEN3 = 3'd3;
  localparam logic [2:0] SEQ_LEN4 = 3'd4;

  // Class of a byte seen where a lead is expected.
  typedef enum logic [2:0] {
    LEAD_ASCII,
    LEAD_LEN2,
    LEAD_LEN3,
    LEAD_LEN4,
    LEAD_BAD
  } lead_kind_t;

  // Work for one input beat: rep_cnt replacement characters first, then
  // raw_cnt bytes taken from raw[0] upward.
  typedef struct packed {
    logic [2:0]      rep_cnt;
    logic [2:0]      raw_cnt;
    logic [3:0][7:0] raw;
  } cmd_t;

  function automatic logic [7:0] repl_byte(input logic [1:0] phase);
    logic [7:0] b;
    case (phase)
      REPL_PH0: b = REPL_BYTE0;
      REPL_PH1: b = REPL_BYTE1;
      default:  b = REPL_BYTE2;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/u8san_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u8san_front
// Takes one input byte a cycle while the command queue has room, tracks
// the open sequence and turns each byte into a command for the back part.
// ----------------------------------------------------------------------------
module u8san_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [7:0]      in_byte,
  input  wire logic            in_eos,
  input  wire logic            q_full,
  output logic                 push,
  output u8san_pkg::cmd_t      push_cmd,
  output logic                 idle
);

  logic [1:0]  held_count;
  logic [2:0]  expected_length;
  logic [20:0] partial_codepoint;
  logic [7:0]  held_bytes [3];

  logic [1:0]  held_count_next;
  logic [2:0]  expected_length_next;
  logic [20:0] partial_codepoint_next;

  u8san_pkg::lead_kind_t kind;
  logic [2:0]  lead_len;
  logic [20:0] lead_cp;
  logic        is_cont;
  logic [20:0] cp_ext;
  logic [2:0]  total;
  logic        complete;
  logic [20:0] min_cp;
  logic        cp_ok;
  logic        wr_lead;
  logic        wr_cont;
  logic        accept;
  u8san_pkg::cmd_t cmd;

  assign accept   = in_valid && !q_full;
  assign in_ready = !q_full;
  assign idle     = (held_count == 2'd0);
  assign is_cont  = (in_byte[7:6] == 2'b10);
  assign cp_ext   = {partial_codepoint[14:0], in_byte[5:0]};
  assign total    = {1'b0, held_count} + 3'd1;
  assign complete = (held_count != 2'd0) && is_cont && !(total < expected_length);

  always_comb begin
    kind     = u8san_pkg::LEAD_BAD;
    lead_len = 3'd0;
    lead_cp  = 21'd0;
    if (in_byte[7] == 1'b0) begin
      kind = u8san_pkg::LEAD_ASCII;
    end else if (in_byte[7:5] == 3'b110) begin
      kind     = u8san_pkg::LEAD_LEN2;
      lead_len = u8san_pkg::SEQ_LEN2;
      lead_cp  = {16'd0, in_byte[4:0]};
    end else if (in_byte[7:4] == 4'b1110) begin
      kind     = u8san_pkg::LEAD_LEN3;
      lead_len = u8san_pkg::SEQ_LEN3;
      lead_cp  = {17'd0, in_byte[3:0]};
    end else if (in_byte[7:3] == 5'b11110) begin
      kind     = u8san_pkg::LEAD_LEN4;
      lead_len = u8san_pkg::SEQ_LEN4;
      lead_cp  = {18'd0, in_byte[2:0]};
    end
  end

  always_comb begin
    case (expected_length)
      u8san_pkg::SEQ_LEN2: min_cp = u8san_pkg::CP_MIN_LEN2;
      u8san_pkg::SEQ_LEN3: min_cp = u8san_pkg::CP_MIN_LEN3;
      default:             min_cp = u8san_pkg::CP_MIN_LEN4;
    endcase
    cp_ok = !(cp_ext < min_cp || cp_ext > u8san_pkg::CP_MAX ||
              (cp_ext >= u8san_pkg::CP_SURR_LO && cp_ext <= u8san_pkg::CP_SURR_HI));
  end

  always_comb begin
    cmd.rep_cnt            = 3'd0;
    cmd.raw_cnt            = 3'd0;
    cmd.raw[0]             = in_byte;
    cmd.raw[1]             = (held_count >= 2'd2) ? held_bytes[1] : in_byte;
    cmd.raw[2]             = (held_count == 2'd3) ? held_bytes[2] : in_byte;
    cmd.raw[3]             = in_byte;
    held_count_next        = held_count;
    expected_length_next   = expected_length;
    partial_codepoint_next = partial_codepoint;
    wr_lead                = 1'b0;
    wr_cont                = 1'b0;

    if (held_count == 2'd0 || !is_cont) begin
      // Whatever is held is broken; the byte starts afresh.
      cmd.rep_cnt            = {1'b0, held_count};
      held_count_next        = 2'd0;
      expected_length_next   = 3'd0;
      partial_codepoint_next = 21'd0;
      case (kind)
        u8san_pkg::LEAD_ASCII: begin
          cmd.raw_cnt = 3'd1;
        end
        u8san_pkg::LEAD_LEN2, u8san_pkg::LEAD_LEN3, u8san_pkg::LEAD_LEN4: begin
          wr_lead                = 1'b1;
          held_count_next        = 2'd1;
          expected_length_next   = lead_len;
          partial_codepoint_next = lead_cp;
        end
        default: begin
          cmd.rep_cnt = {1'b0, held_count} + 3'd1;
        end
      endcase
    end else if (!complete) begin
      wr_cont                = 1'b1;
      held_count_next        = held_count + 2'd1;
      partial_codepoint_next = cp_ext;
    end else begin
      // The held bytes come first; raw[] places this byte right after them.
      if (held_count == 2'd1) begin
        cmd.raw[0] = held_bytes[0];
      end else begin
        cmd.raw[0] = held_bytes[0];
      end
      if (cp_ok) begin
        cmd.raw_cnt = total;
      end else begin
        cmd.rep_cnt = total;
      end
      held_count_next        = 2'd0;
      expected_length_next   = 3'd0;
      partial_codepoint_next = 21'd0;
    end

    if (in_eos) begin
      cmd.rep_cnt            = cmd.rep_cnt + {1'b0, held_count_next};
      held_count_next        = 2'd0;
      expected_length_next   = 3'd0;
      partial_codepoint_next = 21'd0;
    end
  end

  assign push     = accept && (cmd.rep_cnt != 3'd0 || cmd.raw_cnt != 3'd0);
  assign push_cmd = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count        <= 2'd0;
      expected_length   <= 3'd0;
      partial_codepoint <= 21'd0;
    end else if (accept) begin
      held_count        <= held_count_next;
      expected_length   <= expected_length_next;
      partial_codepoint <= partial_codepoint_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && wr_lead) begin
      held_bytes[0] <= in_byte;
    end
    if (accept && wr_cont && held_count == 2'd1) begin
      held_bytes[1] <= in_byte;
    end
    if (accept && wr_cont && held_count == 2'd2) begin
      held_bytes[2] <= in_byte;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/u8san_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u8san_queue
// Small first-in first-out queue of commands between front and back.
// ----------------------------------------------------------------------------
module u8san_queue #(
  parameter int DEPTH = u8san_pkg::QUEUE_DEPTH
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire u8san_pkg::cmd_t push_cmd,
  input  wire logic            pop,
  output u8san_pkg::cmd_t      head_cmd,
  output logic                 full,
  output logic                 not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  u8san_pkg::cmd_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head_cmd  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/u8san_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u8san_back
// Expands the command at the head of the queue into output beats through a
// registered output stage, one byte a cycle while out_ready allows it.
// ----------------------------------------------------------------------------
module u8san_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cmd_valid,
  input  wire u8san_pkg::cmd_t cmd,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [7:0]           out_byte,
  output logic                 out_rep,
  output logic                 out_last
);

  logic [2:0] rep_done;
  logic [1:0] phase;
  logic [1:0] raw_idx;

  logic       load;
  logic       in_rep;
  logic       is_last;
  logic [7:0] next_byte;

  assign load   = cmd_valid && (!out_valid || out_ready);
  assign in_rep = (rep_done != cmd.rep_cnt);
  assign pop    = load && is_last;

  always_comb begin
    if (in_rep) begin
      next_byte = u8san_pkg::repl_byte(phase);
      is_last   = (phase == u8san_pkg::REPL_PH2) &&
                  (rep_done + 3'd1 == cmd.rep_cnt) && (cmd.raw_cnt == 3'd0);
    end else begin
      next_byte = cmd.raw[raw_idx];
      is_last   = ({1'b0, raw_idx} + 3'd1 == cmd.raw_cnt);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rep_done  <= 3'd0;
      phase     <= u8san_pkg::REPL_PH0;
      raw_idx   <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        if (is_last) begin
          rep_done <= 3'd0;
          phase    <= u8san_pkg::REPL_PH0;
          raw_idx  <= 2'd0;
        end else if (in_rep) begin
          if (phase == u8san_pkg::REPL_PH2) begin
            phase    <= u8san_pkg::REPL_PH0;
            rep_done <= rep_done + 3'd1;
          end else begin
            phase <= phase + 2'd1;
          end
        end else begin
          raw_idx <= raw_idx + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= next_byte;
      out_rep  <= in_rep;
      out_last <= is_last;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/utf8_lossy_sanitizer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_lossy_sanitizer
// Streaming UTF-8 validator that replaces every bad byte with U+FFFD.
// ----------------------------------------------------------------------------
// The block takes one raw byte per input beat and produces well-formed UTF-8,
// one byte per output beat. ASCII passes straight through; a multi-byte
// sequence is held until it is complete and then passes whole if its code
// point is in range, not overlong and not a surrogate, or otherwise becomes
// one EF BF BD per byte. A byte that breaks an open sequence first flushes
// the held bytes as replacements and is then taken as a new lead. An input
// beat with tlast set flushes whatever is still held. The output tlast marks
// the final byte caused by one input beat (not a frame end), and tuser marks
// bytes of a replacement character. An input beat that causes no output
// (a held lead or continuation byte) produces no output beat. The front
// part takes one input beat per cycle as long as the command queue
// (QUEUE_DEPTH entries) has room; the back part sends one output byte per
// cycle while the output is not stalled, so the sustained input rate
// falls as the mean number of output bytes per input beat (0 to 12) grows.
// An input beat reaches its first output beat through the command queue
// and the output register. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module utf8_lossy_sanitizer #(
  parameter int QUEUE_DEPTH = u8san_pkg::QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  wire logic       s_axis_tlast,   // end_of_stream
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
  output logic            m_axis_tuser,   // [0] is_replacement
  output logic            m_axis_tlast    // last_in_run
);

  logic            push;
  u8san_pkg::cmd_t push_cmd;
  logic            pop;
  u8san_pkg::cmd_t head_cmd;
  logic            q_full;
  logic            q_not_empty;
  logic            front_idle;

  // Front: classifies each byte and tracks the open sequence.
  u8san_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_byte  (s_axis_tdata),
    .in_eos   (s_axis_tlast),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd),
    .idle     (front_idle)
  );

  // Queue: lets the front keep accepting while the back drains a burst.
  u8san_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .head_cmd  (head_cmd),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  // Back: expands commands into output beats behind a register stage.
  u8san_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_not_empty),
    .cmd       (head_cmd),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_byte  (m_axis_tdata),
    .out_rep   (m_axis_tuser),
    .out_last  (m_axis_tlast)
  );

  // A replacement beat carries one of the three bytes of U+FFFD.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |->
      (m_axis_tdata == u8san_pkg::REPL_BYTE0 || m_axis_tdata == u8san_pkg::REPL_BYTE1 ||
       m_axis_tdata == u8san_pkg::REPL_BYTE2))
    else $error("replacement beat with a foreign byte");

  // A replacement character is never cut after its first byte.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser && m_axis_tdata == u8san_pkg::REPL_BYTE0 |->
      !m_axis_tlast)
    else $error("run ends inside a replacement character");

  // The end-of-stream flag leaves nothing held.
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> front_idle)
    else $error("bytes still held after end of stream");

endmodule
`default_nettype wire

FILE: dv/tb_utf8_lossy_sanitizer.sv
// ----------------------------------------------------------------------------
// tb_utf8_lossy_sanitizer
// Self-checking stream testbench for the UTF-8 sanitizer.
// ----------------------------------------------------------------------------
// Raw bytes are sent on the slave side and the sanitized bytes are checked on
// the master side against a behavioral model of the sanitizer. The stimulus
// starts with directed sequences (byte extremes, bad leads, overlong, surrogate
// and out-of-range code points, broken sequences, end of stream). Random
// traffic follows, mostly well-formed UTF-8 with some noise. Both sides insert
// random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_utf8_lossy_sanitizer;

  // One raw byte waiting to be sent, with the idle cycles to insert before it.
  // A byte marked drain is held back until every sanitized byte has arrived.
  typedef struct {
    logic [7:0] data;
    logic       eos;
    logic       drain;
    int         gap;
  } raw_beat_t;

  // One sanitized byte as the master side should present it.
  typedef struct {
    logic [7:0] data;
    logic       repl;
    logic       last;
  } clean_beat_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;

  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;   // [7:0] in_byte
  logic       s_axis_tlast = 1'b0;    // end_of_stream
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // [7:0] out_byte
  logic       m_axis_tuser;           // [0] is_replacement
  logic       m_axis_tlast;           // last_in_run

  utf8_lossy_sanitizer dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Safety net against a hung handshake on either side.
  initial begin
    #8000000;
    $display("simulation failed");
    $finish;
  end

  raw_beat_t   raw_bytes_q[$];
  clean_beat_t clean_bytes_q[$];
  int          fail_cnt = 0;
  logic        drain_next = 1'b0;
  int          tx_calm = 0;

  // Model of the sanitizer state: the open sequence and its partial code point.
  logic [7:0]  seq_bytes[3];
  int          seq_held = 0;
  logic [2:0]  seq_len = 3'd0;
  logic [20:0] seq_cp = 21'd0;

  // Mostly short gaps, sometimes a long one.
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic note_failure(input string msg);
    fail_cnt++;
    if (fail_cnt <= 10) $display("mismatch: %s", msg);
  endtask

  // --------------------------------------------------------------------------
  // Sanitizer model. Each accepted raw byte appends its sanitized bytes to
  // clean_bytes_q, and the final one of the run carries the last flag.
  // --------------------------------------------------------------------------
  function automatic void emit(input logic [7:0] b, input logic repl);
    clean_beat_t c;
    c.data = b;
    c.repl = repl;
    c.last = 1'b0;
    clean_bytes_q.insert(clean_bytes_q.size(), c);
  endfunction

  function automatic void emit_fffd();
    emit(u8san_pkg::REPL_BYTE0, 1'b1);
    emit(u8san_pkg::REPL_BYTE1, 1'b1);
    emit(u8san_pkg::REPL_BYTE2, 1'b1);
  endfunction

  function automatic u8san_pkg::lead_kind_t lead_class(input logic [7:0] b);
    if (!b[7]) return u8san_pkg::LEAD_ASCII;
    if (b[7:5] == 3'b110) return u8san_pkg::LEAD_LEN2;
    if (b[7:4] == 4'b1110) return u8san_pkg::LEAD_LEN3;
    if (b[7:3] == 5'b11110) return u8san_pkg::LEAD_LEN4;
    return u8san_pkg::LEAD_BAD;
  endfunction

  function automatic void drop_sequence();
    seq_held = 0;
    seq_len  = 3'd0;
    seq_cp   = 21'd0;
  endfunction

  // Every held byte of an abandoned sequence becomes one U+FFFD.
  function automatic void flush_sequence();
    for (int k = 0; k < seq_held; k++) emit_fffd();
    drop_sequence();
  endfunction

  function automatic void open_sequence(input logic [7:0] b, input logic [2:0] len,
                                        input logic [20:0] cp);
    seq_bytes[0] = b;
    seq_held     = 1;
    seq_len      = len;
    seq_cp       = cp;
  endfunction

  function automatic void start_lead(input logic [7:0] b);
    case (lead_class(b))
      u8san_pkg::LEAD_ASCII: emit(b, 1'b0);
      u8san_pkg::LEAD_LEN2:  open_sequence(b, u8san_pkg::SEQ_LEN2, {16'd0, b[4:0]});
      u8san_pkg::LEAD_LEN3:  open_sequence(b, u8san_pkg::SEQ_LEN3, {17'd0, b[3:0]});
      u8san_pkg::LEAD_LEN4:  open_sequence(b, u8san_pkg::SEQ_LEN4, {18'd0, b[2:0]});
      default:               emit_fffd();
    endcase
  endfunction

  function automatic void sanitize_byte(input logic [7:0] b, input logic eos);
    logic [20:0] cp;
    logic [20:0] min_cp;
    int          total;
    int          first;
    logic        good;
    first = clean_bytes_q.size();
    if (seq_held == 0) begin
      start_lead(b);
    end else if (b[7:6] != 2'b10) begin
      // A byte that breaks the open sequence is taken again as a lead.
      flush_sequence();
      start_lead(b);
    end else begin
      cp    = {seq_cp[14:0], b[5:0]};
      total = seq_held + 1;
      if (total < seq_len) begin
        seq_bytes[seq_held] = b;
        seq_held++;
        seq_cp = cp;
      end else begin
        case (seq_len)
          u8san_pkg::SEQ_LEN2: min_cp = u8san_pkg::CP_MIN_LEN2;
          u8san_pkg::SEQ_LEN3: min_cp = u8san_pkg::CP_MIN_LEN3;
          default:             min_cp = u8san_pkg::CP_MIN_LEN4;
        endcase
        good = !(cp < min_cp || cp > u8san_pkg::CP_MAX ||
                 (cp >= u8san_pkg::CP_SURR_LO && cp <= u8san_pkg::CP_SURR_HI));
        if (good) begin
          for (int k = 0; k < seq_held; k++) emit(seq_bytes[k], 1'b0);
          emit(b, 1'b0);
        end else begin
          for (int k = 0; k < total; k++) emit_fffd();
        end
        drop_sequence();
      end
    end
    if (eos) flush_sequence();
    if (clean_bytes_q.size() > first) clean_bytes_q[clean_bytes_q.size() - 1].last = 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  task automatic push_raw(input logic [7:0] b, input logic eos);
    raw_beat_t r;
    r.data  = b;
    r.eos   = eos;
    r.drain = drain_next;
    drain_next = 1'b0;
    // Occasional stretches without any gap on the sending side.
    if (tx_calm > 0) begin
      tx_calm--;
      r.gap = 0;
    end else begin
      r.gap = draw_gap();
      if ($urandom_range(0, 49) == 0) tx_calm = $urandom_range(20, 60);
    end
    raw_bytes_q.insert(raw_bytes_q.size(), r);
  endtask

  function automatic logic rand_eos();
    return ($urandom_range(0, 19) == 0);
  endfunction

  // Sends the UTF-8 encoding of a valid code point of the given length.
  task automatic push_valid_char(input int len);
    logic [20:0] cp;
    case (len)
      2: cp = 21'($urandom_range(32'h80, 32'h7FF));
      3: begin
        cp = 21'($urandom_range(32'h800, 32'hFFFF));
        if (cp >= u8san_pkg::CP_SURR_LO && cp <= u8san_pkg::CP_SURR_HI) cp = cp ^ 21'h1000;
      end
      default: cp = 21'($urandom_range(32'h10000, 32'h10FFFF));
    endcase
    case (len)
      2: begin
        push_raw({3'b110, cp[10:6]}, rand_eos());
        push_raw({2'b10, cp[5:0]}, rand_eos());
      end
      3: begin
        push_raw({4'b1110, cp[15:12]}, rand_eos());
        push_raw({2'b10, cp[11:6]}, rand_eos());
        push_raw({2'b10, cp[5:0]}, rand_eos());
      end
      default: begin
        push_raw({5'b11110, cp[20:18]}, rand_eos());
        push_raw({2'b10, cp[17:12]}, rand_eos());
        push_raw({2'b10, cp[11:6]}, rand_eos());
        push_raw({2'b10, cp[5:0]}, rand_eos());
      end
    endcase
  endtask

  // A lead with random payload followed by n random continuation bytes. The
  // code point may come out overlong, a surrogate or above the maximum.
  task automatic push_rough_char(input int len, input int n_cont);
    logic [7:0] lead;
    lead = 8'($urandom_range(0, 255));
    case (len)
      2:       lead = {3'b110, lead[4:0]};
      3:       lead = {4'b1110, lead[3:0]};
      default: lead = {5'b11110, lead[2:0]};
    endcase
    push_raw(lead, rand_eos());
    for (int k = 0; k < n_cont; k++) push_raw({2'b10, 6'($urandom_range(0, 63))}, rand_eos());
  endtask

  // --------------------------------------------------------------------------
  // Driver: presents the pending raw bytes, and on each accepted beat runs the
  // model so the expected sanitized bytes are queued in order.
  // --------------------------------------------------------------------------
  int hold_cnt = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      hold_cnt      <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) sanitize_byte(s_axis_tdata, s_axis_tlast);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (raw_bytes_q.size() == 0) begin
          s_axis_tvalid <= 1'b0;
        end else if (hold_cnt < raw_bytes_q[0].gap) begin
          hold_cnt      <= hold_cnt + 1;
          s_axis_tvalid <= 1'b0;
        end else if (raw_bytes_q[0].drain && clean_bytes_q.size() != 0) begin
          // Let the block run completely dry before this beat.
          s_axis_tvalid <= 1'b0;
        end else begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= raw_bytes_q[0].data;
          s_axis_tlast  <= raw_bytes_q[0].eos;
          raw_bytes_q.pop_front();
          hold_cnt      <= 0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: back-pressures the master side at random and checks every beat
  // against the oldest expected sanitized byte.
  // --------------------------------------------------------------------------
  int stall_left = 0;
  int rx_calm = 0;

  task automatic check_beat();
    clean_beat_t want;
    if (clean_bytes_q.size() == 0) begin
      note_failure($sformatf("unexpected beat data=%02h user=%0b last=%0b",
                             m_axis_tdata, m_axis_tuser, m_axis_tlast));
    end else begin
      want = clean_bytes_q.pop_front();
      if (m_axis_tdata !== want.data || m_axis_tuser !== want.repl ||
          m_axis_tlast !== want.last)
        note_failure($sformatf({"expected data=%02h user=%0b last=%0b, ",
                                "got data=%02h user=%0b last=%0b"},
                               want.data, want.repl, want.last,
                               m_axis_tdata, m_axis_tuser, m_axis_tlast));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
      rx_calm       <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_beat();
      if (stall_left != 0) begin
        stall_left    <= stall_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (rx_calm != 0) rx_calm <= rx_calm - 1;
        else if ($urandom_range(0, 199) == 0) rx_calm <= $urandom_range(50, 150);
        else if ($urandom_range(0, 3) == 0) stall_left <= draw_gap();
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run.
  // --------------------------------------------------------------------------
  initial begin
    int next_drain;
    int kind;
    int len;
    logic [7:0] b;

    // Plain ASCII at both ends; end of stream with nothing held.
    push_raw(8'h00, 1'b0);
    push_raw(8'h7F, 1'b1);
    // Invalid leads: a stray continuation byte and a byte above F7.
    push_raw(8'h80, 1'b0);
    push_raw(8'hFF, 1'b0);
    // Smallest two-byte character, then an overlong two-byte form.
    push_raw(8'hC2, 1'b0);
    push_raw(8'h80, 1'b0);
    push_raw(8'hC1, 1'b0);
    push_raw(8'hBF, 1'b0);
    // A surrogate encoded in three bytes.
    push_raw(8'hED, 1'b0);
    push_raw(8'hA0, 1'b0);
    push_raw(8'h80, 1'b0);
    // Highest valid code point, then one above it (twelve output bytes).
    push_raw(8'hF4, 1'b0);
    push_raw(8'h8F, 1'b0);
    push_raw(8'hBF, 1'b0);
    push_raw(8'hBF, 1'b0);
    push_raw(8'hF4, 1'b0);
    push_raw(8'h90, 1'b0);
    push_raw(8'h80, 1'b0);
    push_raw(8'h80, 1'b0);
    // A sequence broken by ASCII, and one broken by a new lead.
    push_raw(8'hE2, 1'b0);
    push_raw(8'h41, 1'b0);
    push_raw(8'hF0, 1'b0);
    push_raw(8'hE2, 1'b0);
    // End of stream flushes the open sequence, then on a lone lead.
    push_raw(8'h82, 1'b1);
    push_raw(8'hF8, 1'b0);
    push_raw(8'hF0, 1'b1);

    // Random traffic, pausing until drained every so often.
    drain_next = 1'b1;
    next_drain = raw_bytes_q.size() + 90;
    while (raw_bytes_q.size() < 380) begin
      if (raw_bytes_q.size() >= next_drain) begin
        drain_next = 1'b1;
        next_drain += 90;
      end
      kind = $urandom_range(0, 99);
      len  = $urandom_range(2, 4);
      if (kind < 25) begin
        push_raw({1'b0, 7'($urandom_range(0, 127))}, rand_eos());
      end else if (kind < 62) begin
        push_valid_char(len);
      end else if (kind < 77) begin
        push_rough_char(len, len - 1);
      end else if (kind < 89) begin
        // Truncated sequence followed by a byte that is not a continuation.
        push_rough_char(len, $urandom_range(0, len - 2));
        b = 8'($urandom_range(0, 255));
        if (b[7:6] == 2'b10) b[6] = 1'b1;
        push_raw(b, rand_eos());
      end else begin
        push_raw(8'($urandom_range(0, 255)), rand_eos());
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (raw_bytes_q.size() != 0 || s_axis_tvalid) @(negedge clk);
    while (clean_bytes_q.size() != 0) @(negedge clk);
    // Any extra beat during this tail is flagged by the monitor.
    repeat (20) @(negedge clk);

    if (clean_bytes_q.size() != 0)
      note_failure($sformatf("%0d expected beats never arrived", clean_bytes_q.size()));
    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: utf8_lossy_sanitizer.f
hw/rtl/u8san_pkg.sv
hw/rtl/u8san_front.sv
hw/rtl/u8san_queue.sv
hw/rtl/u8san_back.sv
hw/rtl/utf8_lossy_sanitizer.sv
dv/tb_utf8_lossy_sanitizer.sv
